### rtl/tdp_pkg.sv
// ---------------------------------------------------------------------------
// tdp_pkg: shared types and constants of the task device
// Operation codes, register indexes, status bit positions and the payload
// structs of the input and result channels.
// ---------------------------------------------------------------------------
package tdp_pkg;

  // operation codes of one input item
  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_TICK      = 3'd2,
    OP_POWER_OFF = 3'd3,
    OP_POWER_ON  = 3'd4
  } op_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SET_DELAY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WORK_DELAY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESUME_DELAY = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_INTERRUPT    = 2'd3;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CountW   = 33;

  // status byte bit positions
  localparam int unsigned BitStart  = 0;
  localparam int unsigned BitWork   = 1;
  localparam int unsigned BitFinish = 2;

  // offsets reachable through the 8 bit address
  localparam int unsigned AddrSpan = 256;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] address_offset;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       task_started;
    logic       request_rejected;
    logic       task_done_interrupt;
    logic       working;
  } out_t;

endpackage

### rtl/tdp_chan_if.sv
// ---------------------------------------------------------------------------
// tdp_chan_if: valid/ready channel
// One transfer happens at a rising edge with valid and ready both high.
// ---------------------------------------------------------------------------
interface tdp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tdp_ram.sv
// ---------------------------------------------------------------------------
// tdp_ram: generic single write, single read RAM
// One write port and one read port with registered read data and read enable.
// ---------------------------------------------------------------------------
module tdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/task_device_with_power_pause.sv
// ---------------------------------------------------------------------------
// task_device_with_power_pause: memory-mapped task device with power pause
// Byte store with a status byte at offset 0, a start/reject check, a tick
// countdown, and saving and restoring of the remaining count across power.
// ---------------------------------------------------------------------------
// The result of a transfer is in the result register in the cycle after it
// is accepted; read data comes from the store RAM's registered port.
// Throughput: one item per cycle while the result side takes results.
// Reset clears status, countdown, saved count and config at once; every
// store byte reads as zero until written, through one valid bit per byte.
module task_device_with_power_pause #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tdp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tdp_pkg::CfgDataW-1:0] cfg_data_i,
  tdp_chan_if.sink                     in_i,
  tdp_chan_if.source                   out_o
);
  import tdp_pkg::*;

  // bytes reachable by the address and RAM index width
  localparam int unsigned Used = (STORE_BYTES < AddrSpan) ? STORE_BYTES : AddrSpan;
  localparam int unsigned IdxW = $clog2(Used);

  // configuration
  logic [CfgDataW-1:0] set_delay_q, work_delay_q, resume_delay_q;
  logic                intr_q;

  // device state
  logic              work_q, work_d;
  logic              fin_q, fin_d;
  logic              counting_q, counting_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] saved_q, saved_d;
  logic              saved_vld_q, saved_vld_d;
  logic [Used-1:0]   vld_q;

  // result register
  logic       res_vld_q;
  logic       rd_ram_q, rd_ram_d;
  logic [7:0] rd_byte_q, rd_byte_d;
  logic       started_q, started_d;
  logic       rejected_q, rejected_d;
  logic       done_q, done_d;

  // handshake
  logic       accept;
  in_t        item;
  logic       in_range;
  logic [IdxW-1:0] idx;
  logic       ram_we, ram_re;
  logic [7:0] ram_rdata;

  assign in_i.ready = !res_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign item       = in_i.data;
  assign in_range   = {1'b0, item.address_offset} < 9'(Used);
  assign idx        = item.address_offset[IdxW-1:0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_delay_q    <= '0;
      work_delay_q   <= '0;
      resume_delay_q <= '0;
      intr_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_DELAY:    set_delay_q    <= cfg_data_i;
        CFG_WORK_DELAY:   work_delay_q   <= cfg_data_i;
        CFG_RESUME_DELAY: resume_delay_q <= cfg_data_i;
        CFG_INTERRUPT:    intr_q         <= cfg_data_i[0];
      endcase
    end
  end

  // item decode and state update
  always_comb begin
    work_d      = work_q;
    fin_d       = fin_q;
    counting_d  = counting_q;
    cnt_d       = cnt_q;
    saved_d     = saved_q;
    saved_vld_d = saved_vld_q;
    rd_ram_d    = 1'b0;
    rd_byte_d   = '0;
    started_d   = 1'b0;
    rejected_d  = 1'b0;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (op_e'(item.operation))
      OP_READ: begin
        if (item.address_offset == 8'd0) begin
          rd_byte_d            = '0;
          rd_byte_d[BitWork]   = work_q;
          rd_byte_d[BitFinish] = fin_q;
        end else if (in_range && vld_q[idx]) begin
          rd_ram_d = 1'b1;
          ram_re   = accept;
        end
      end
      OP_WRITE: begin
        if (item.address_offset == 8'd0) begin
          if (item.write_byte[BitStart]) begin
            if (work_q) begin
              rejected_d = 1'b1;
            end else begin
              work_d     = 1'b1;
              fin_d      = 1'b0;
              cnt_d      = {1'b0, set_delay_q} + {1'b0, work_delay_q};
              counting_d = 1'b1;
              started_d  = 1'b1;
            end
          end
        end else if (in_range) begin
          ram_we = accept;
        end
      end
      OP_TICK: begin
        if (counting_q) begin
          if (cnt_q <= CountW'(1)) begin
            cnt_d      = '0;
            counting_d = 1'b0;
            work_d     = 1'b0;
            fin_d      = 1'b1;
            done_d     = 1'b1;
          end else begin
            cnt_d = cnt_q - CountW'(1);
          end
        end
      end
      OP_POWER_OFF: begin
        if (work_q && counting_q) begin
          if (intr_q) begin
            saved_d     = cnt_q;
            saved_vld_d = 1'b1;
          end
          counting_d = 1'b0;
        end
      end
      OP_POWER_ON: begin
        if (work_q && !counting_q) begin
          cnt_d      = saved_vld_q ? saved_q : {1'b0, resume_delay_q};
          counting_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= 1'b0;
      fin_q       <= 1'b0;
      counting_q  <= 1'b0;
      cnt_q       <= '0;
      saved_q     <= '0;
      saved_vld_q <= 1'b0;
      vld_q       <= '0;
    end else if (accept) begin
      work_q      <= work_d;
      fin_q       <= fin_d;
      counting_q  <= counting_d;
      cnt_q       <= cnt_d;
      saved_q     <= saved_d;
      saved_vld_q <= saved_vld_d;
      if (ram_we) begin
        vld_q[idx] <= 1'b1;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      res_vld_q <= in_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_ram_q   <= rd_ram_d;
      rd_byte_q  <= rd_byte_d;
      started_q  <= started_d;
      rejected_q <= rejected_d;
      done_q     <= done_d;
    end
  end

  // byte store
  tdp_ram #(
    .WIDTH (8),
    .DEPTH (Used)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (item.write_byte),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  // result channel
  assign out_o.valid                    = res_vld_q;
  assign out_o.data.read_byte           = rd_ram_q ? ram_rdata : rd_byte_q;
  assign out_o.data.task_started        = started_q;
  assign out_o.data.request_rejected    = rejected_q;
  assign out_o.data.task_done_interrupt = done_q;
  assign out_o.data.working             = work_q;

  // working and finished never set together
  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(work_q && fin_q))
    else $error("working and finished both set");

  // countdown only runs during a task
  a_count_in_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counting_q |-> work_q)
    else $error("counting without working");

  // a start is either taken or rejected
  a_start_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(started_q && rejected_q))
    else $error("start both accepted and rejected");

  // a finished task leaves working clear in the same result
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && done_q) |-> !work_q)
    else $error("interrupt with working still set");

endmodule

### tb/tdp_task_checker.sv
// ---------------------------------------------------------------------------
// tdp_task_checker: response predictor and scoreboard of the task device
// Watches the config port and both channels, predicts one response per
// input transfer and compares each response transfer with the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_task_checker
  import tdp_pkg::*;
#(
  parameter int unsigned StoreBytes = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_t                out_data_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  // shadow copy of the device state and its registers
  logic [7:0]          byte_mem [StoreBytes];
  logic [CountW-1:0]   countdown;
  logic                counting;
  logic [CountW-1:0]   saved_count;
  logic                saved_valid;
  logic [CfgDataW-1:0] set_delay;
  logic [CfgDataW-1:0] work_delay;
  logic [CfgDataW-1:0] resume_delay;
  logic                interruptible;

  out_t        response_q[$];
  int unsigned err_cnt;

  // state after reset
  task automatic clear_device();
    foreach (byte_mem[i]) byte_mem[i] = 8'h00;
    countdown     = '0;
    counting      = 1'b0;
    saved_count   = '0;
    saved_valid   = 1'b0;
    set_delay     = '0;
    work_delay    = '0;
    resume_delay  = '0;
    interruptible = 1'b0;
  endtask

  // apply one item to the shadow state and return the response it causes
  function automatic out_t device_response(input in_t item);
    out_t       resp;
    logic       busy;
    logic [7:0] off;
    logic [7:0] wdata;
    resp  = '0;
    off   = item.address_offset;
    wdata = item.write_byte;
    busy  = byte_mem[0][BitWork];
    case (item.operation)
      OP_READ: begin
        if (int'(off) < StoreBytes) resp.read_byte = byte_mem[off];
      end
      OP_WRITE: begin
        if (off == 8'd0) begin
          // status byte only reacts to the start bit
          if (wdata[BitStart]) begin
            if (busy) begin
              resp.request_rejected = 1'b1;
            end else begin
              byte_mem[0][BitWork]   = 1'b1;
              byte_mem[0][BitFinish] = 1'b0;
              countdown = {1'b0, set_delay} + {1'b0, work_delay};
              counting  = 1'b1;
              resp.task_started = 1'b1;
            end
          end
        end else if (int'(off) < StoreBytes) begin
          byte_mem[off] = wdata;
        end
      end
      OP_TICK: begin
        if (counting) begin
          if (countdown <= 1) begin
            countdown = '0;
            counting  = 1'b0;
            byte_mem[0][BitFinish] = 1'b1;
            byte_mem[0][BitWork]   = 1'b0;
            resp.task_done_interrupt = 1'b1;
          end else begin
            countdown = countdown - 1'b1;
          end
        end
      end
      OP_POWER_OFF: begin
        if (busy && counting) begin
          if (interruptible) begin
            saved_count = countdown;
            saved_valid = 1'b1;
          end
          counting = 1'b0;
        end
      end
      OP_POWER_ON: begin
        if (busy && !counting) begin
          countdown = saved_valid ? saved_count : {1'b0, resume_delay};
          counting  = 1'b1;
        end
      end
      default: ;
    endcase
    resp.working = byte_mem[0][BitWork];
    return resp;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // config writes, response checks, then prediction of the new transfer
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_resp;
    if (!rst_ni) begin
      clear_device();
      response_q.delete();
      err_cnt   = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_DELAY:    set_delay     = cfg_data_i;
          CFG_WORK_DELAY:   work_delay    = cfg_data_i;
          CFG_RESUME_DELAY: resume_delay  = cfg_data_i;
          CFG_INTERRUPT:    interruptible = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (response_q.size() == 0) begin
          err_cnt++;
          $display("%0t: response transfer with none expected, expected none, actual %0h",
                   $time, out_data_i);
        end else begin
          exp_resp = response_q.pop_front();
          check_field("read_byte", exp_resp.read_byte, out_data_i.read_byte);
          check_field("task_started", 8'(exp_resp.task_started),
                      8'(out_data_i.task_started));
          check_field("request_rejected", 8'(exp_resp.request_rejected),
                      8'(out_data_i.request_rejected));
          check_field("task_done_interrupt", 8'(exp_resp.task_done_interrupt),
                      8'(out_data_i.task_done_interrupt));
          check_field("working", 8'(exp_resp.working), 8'(out_data_i.working));
        end
      end
      // append the predicted response at the tail
      if (in_valid_i && in_ready_i) begin
        response_q = {response_q, device_response(in_data_i)};
      end
      errors_o  <= err_cnt;
      pending_o <= response_q.size();
    end
  end

endmodule

### tb/task_device_with_power_pause_tb.sv
// ---------------------------------------------------------------------------
// task_device_with_power_pause_tb: top of the task device testbench
// Drives directed and random bus accesses, ticks and power events with random
// gaps and result stalls over several register settings; the checker beside
// the device predicts and compares every response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_device_with_power_pause_tb;
  import tdp_pkg::*;

  localparam int unsigned StoreBytes  = 256;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 200;
  localparam logic [2:0]  OpUnusedLo  = 3'd5;
  localparam logic [2:0]  OpUnusedHi  = 3'd7;
  localparam logic [7:0]  StatusOff   = 8'd0;
  localparam logic [7:0]  StartCmd    = 8'h01;
  localparam logic [31:0] DelayMax    = 32'hFFFF_FFFF;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         error_cnt;
  int unsigned         pending_cnt;
  int unsigned         cycle_cnt;
  bit                  send_burst;

  tdp_chan_if #(.T(in_t))  in_if ();
  tdp_chan_if #(.T(out_t)) out_if ();

  task_device_with_power_pause #(
    .STORE_BYTES(StoreBytes)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  tdp_task_checker #(
    .StoreBytes(StoreBytes)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_if.valid),
    .in_ready_i (in_if.ready),
    .in_data_i  (in_if.data),
    .out_valid_i(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_data_i (out_if.data),
    .errors_o   (error_cnt),
    .pending_o  (pending_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // response side: random stalls per transfer, with burst stretches
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          take_burst;
    out_if.ready <= 1'b0;
    taken      = 0;
    take_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 50 == 0) take_burst = ($urandom_range(0, 3) == 0);
      stall = take_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
    end
  end

  // one input transfer after a random gap; valid stays high after it
  task automatic send_item(input logic [2:0] op, input logic [7:0] off,
                           input logic [7:0] wdata);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{operation: op, address_offset: off, write_byte: wdata};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // hold the sender until every predicted response has been taken
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // write all four registers on consecutive edges
  task automatic apply_config(input logic [31:0] set_val, input logic [31:0] work_val,
                              input logic [31:0] resume_val, input logic intr_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SET_DELAY;
    cfg_data <= set_val;
    @(posedge clk_i);
    cfg_idx  <= CFG_WORK_DELAY;
    cfg_data <= work_val;
    @(posedge clk_i);
    cfg_idx  <= CFG_RESUME_DELAY;
    cfg_data <= resume_val;
    @(posedge clk_i);
    cfg_idx  <= CFG_INTERRUPT;
    cfg_data <= {31'd0, intr_val};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // weighted random item: ticks dominate so tasks get to finish
  task automatic send_random_item();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  off;
    logic [7:0]  wdata;
    pick  = $urandom_range(0, 99);
    off   = 8'($urandom_range(0, 255));
    wdata = 8'($urandom_range(0, 255));
    if (pick < 35) begin
      op = OP_TICK;
    end else if (pick < 52) begin
      op = OP_WRITE;
      if (pick < 44) off = StatusOff;
    end else if (pick < 72) begin
      op = OP_READ;
      if (pick < 58) off = StatusOff;
    end else if (pick < 82) begin
      op = OP_POWER_OFF;
    end else if (pick < 92) begin
      op = OP_POWER_ON;
    end else begin
      op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    end
    send_item(op, off, wdata);
  endtask

  // stimulus and verdict
  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    send_burst   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // store extremes, status write without start, zero-delay task, reject
    send_item(OP_READ, StatusOff, 8'h00);
    send_item(OP_WRITE, 8'd255, 8'hFF);
    send_item(OP_READ, 8'd255, 8'h00);
    send_item(OP_WRITE, 8'd1, 8'h00);
    send_item(OP_READ, 8'd1, 8'hFF);
    send_item(OP_WRITE, StatusOff, 8'hFE);
    send_item(OP_WRITE, StatusOff, StartCmd);
    send_item(OP_WRITE, StatusOff, 8'hFF);
    send_item(OP_READ, StatusOff, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_READ, StatusOff, 8'h00);
    // power events while idle and unused operation codes
    send_item(OP_POWER_OFF, 8'd0, 8'h00);
    send_item(OP_POWER_ON, 8'd0, 8'h00);
    send_item(OpUnusedLo, 8'hFF, 8'hFF);
    send_item(OpUnusedHi, 8'h00, 8'h00);
    wait_idle();

    // largest delays, paused without a save, resumed from the resume delay
    apply_config(DelayMax, DelayMax, 32'd2, 1'b0);
    send_item(OP_WRITE, StatusOff, StartCmd);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_POWER_ON, 8'd0, 8'h00);
    send_item(OP_POWER_OFF, 8'd0, 8'h00);
    send_item(OP_POWER_OFF, 8'd0, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_POWER_ON, 8'd0, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);
    wait_idle();

    // interruptible pause saves the remaining count and resumes from it
    apply_config(32'd3, 32'd0, 32'd0, 1'b1);
    send_item(OP_WRITE, StatusOff, StartCmd);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_POWER_OFF, 8'd0, 8'h00);
    send_item(OP_POWER_ON, 8'd0, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);
    send_item(OP_TICK, 8'd0, 8'h00);

    // random phases; set and work delays stay small so tasks keep finishing
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      case (phase)
        0: apply_config(32'd0, 32'd0, 32'd0, 1'b0);
        1: apply_config(32'($urandom_range(0, 6)), 32'($urandom_range(0, 6)),
                        DelayMax, 1'b1);
        default: apply_config(32'($urandom_range(0, 6)), 32'($urandom_range(0, 6)),
                              32'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
      endcase
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
        if (n == PhaseItems / 2) wait_idle();
        send_random_item();
      end
    end

    // drain and settle
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
